// ===== rtl/obbsat_pkg.sv =====
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared types and constants for the oriented-box separating-axis unit.
// ----------------------------------------------------------------------------
package obbsat_pkg;

  localparam int COMP_W    = 16;   // packed vector component
  localparam int D_W       = 17;   // center difference component
  localparam int L_W       = 33;   // candidate axis component (cross product)
  localparam int DM_W      = 49;   // |D.L|
  localparam int RM_W      = 48;   // |Ak.L|, |Bk.L|
  localparam int TERM_W    = 64;   // |Ak.L| * |hk|
  localparam int PAIR_W    = 65;
  localparam int SUM_W     = 67;
  localparam int DIST_SH   = 14;   // aligns |D.L| with the radius sum
  localparam int NUM_AXES  = 15;
  localparam int NUM_FACE  = 6;
  localparam int NUM_TERMS = 6;

  localparam logic [3:0] AXIS_NONE = 4'd15;

  typedef logic [2:0][COMP_W-1:0] v16_t;
  typedef logic [2:0][D_W-1:0]    vd_t;
  typedef logic [2:0][L_W-1:0]    vl_t;

  typedef struct packed {
    logic [47:0] a_center;
    logic [47:0] a_axis_x;
    logic [47:0] a_axis_y;
    logic [47:0] a_axis_z;
    logic [47:0] a_half;
    logic [47:0] b_center;
    logic [47:0] b_axis_x;
    logic [47:0] b_axis_y;
    logic [47:0] b_axis_z;
    logic [47:0] b_half;
  } obbsat_in_t;

  typedef struct packed {
    logic       overlap;
    logic [3:0] split_axis;
  } obbsat_out_t;

  // unpacked box pair as seen by every axis test
  typedef struct packed {
    vd_t                    d;
    v16_t [2:0]             a_ax;
    v16_t [2:0]             b_ax;
    logic [2:0][COMP_W-1:0] a_hm;
    logic [2:0][COMP_W-1:0] b_hm;
  } obbsat_geom_t;

endpackage

// ===== rtl/obbsat_front.sv =====
// ----------------------------------------------------------------------------
// obbsat_front
// Unpacks a request, forms the center difference, half-size magnitudes, the
// fifteen candidate axes and the equal-axis flag; one register stage.
// ----------------------------------------------------------------------------
module obbsat_front (
  input  logic                     clk,
  input  obbsat_pkg::obbsat_in_t   req,
  output obbsat_pkg::obbsat_geom_t geom,
  output obbsat_pkg::vl_t          axes [obbsat_pkg::NUM_AXES],
  output logic                     eq_pair
);
  import obbsat_pkg::*;

  obbsat_geom_t geom_nxt, geom_r;
  vl_t          axes_nxt [NUM_AXES];
  vl_t          axes_r   [NUM_AXES];
  logic         eq_nxt, eq_r;

  v16_t ac, bc, ah, bh;
  logic signed [31:0] pa [9][3];
  logic signed [31:0] pb [9][3];

  always_comb begin
    ac = v16_t'(req.a_center);
    bc = v16_t'(req.b_center);
    ah = v16_t'(req.a_half);
    bh = v16_t'(req.b_half);
    geom_nxt.a_ax[0] = v16_t'(req.a_axis_x);
    geom_nxt.a_ax[1] = v16_t'(req.a_axis_y);
    geom_nxt.a_ax[2] = v16_t'(req.a_axis_z);
    geom_nxt.b_ax[0] = v16_t'(req.b_axis_x);
    geom_nxt.b_ax[1] = v16_t'(req.b_axis_y);
    geom_nxt.b_ax[2] = v16_t'(req.b_axis_z);
    for (int k = 0; k < 3; k++) begin
      geom_nxt.d[k]    = D_W'($signed(bc[k])) - D_W'($signed(ac[k]));
      geom_nxt.a_hm[k] = ah[k][COMP_W-1] ? COMP_W'(~ah[k] + 16'd1) : ah[k];
      geom_nxt.b_hm[k] = bh[k][COMP_W-1] ? COMP_W'(~bh[k] + 16'd1) : bh[k];
    end
    // face axes A0,B0,A1,B1,A2,B2
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        axes_nxt[2*i][k]   = L_W'($signed(geom_nxt.a_ax[i][k]));
        axes_nxt[2*i+1][k] = L_W'($signed(geom_nxt.b_ax[i][k]));
      end
    end
    // cross axes Ai x Bj
    eq_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pa[3*i+j][k] = $signed(geom_nxt.a_ax[i][(k+1)%3]) *
                         $signed(geom_nxt.b_ax[j][(k+2)%3]);
          pb[3*i+j][k] = $signed(geom_nxt.a_ax[i][(k+2)%3]) *
                         $signed(geom_nxt.b_ax[j][(k+1)%3]);
          axes_nxt[NUM_FACE+3*i+j][k] = L_W'(pa[3*i+j][k]) - L_W'(pb[3*i+j][k]);
        end
        if (geom_nxt.a_ax[i] == geom_nxt.b_ax[j]) begin
          eq_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
    axes_r <= axes_nxt;
    eq_r   <= eq_nxt;
  end

  assign geom    = geom_r;
  assign axes    = axes_r;
  assign eq_pair = eq_r;

endmodule

// ===== rtl/obbsat_axis_test.sv =====
// ----------------------------------------------------------------------------
// obbsat_axis_test
// Projection test on one candidate axis: four register stages
// (dot products, radius terms, pair sums, total), then the strict compare.
// ----------------------------------------------------------------------------
module obbsat_axis_test (
  input  logic                     clk,
  input  obbsat_pkg::obbsat_geom_t geom,
  input  obbsat_pkg::vl_t          axis,
  output logic                     sep
);
  import obbsat_pkg::*;

  // stage 1: dot products
  logic signed [49:0] dp [3];
  logic signed [51:0] dsum;
  logic        [51:0] dabs;
  logic signed [48:0] ap [NUM_TERMS][3];
  logic signed [50:0] asum [NUM_TERMS];
  logic        [50:0] aabs [NUM_TERMS];
  v16_t               bx;

  logic [DM_W-1:0]   dist1_r, dist2_r, dist3_r, dist4_r;
  logic [RM_W-1:0]   dm_nxt [NUM_TERMS];
  logic [RM_W-1:0]   dm_r   [NUM_TERMS];
  logic [COMP_W-1:0] hm_r   [NUM_TERMS];
  logic [TERM_W-1:0] term_r [NUM_TERMS];
  logic [PAIR_W-1:0] pair_r [3];
  logic [SUM_W-1:0]  total_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp[k] = $signed(geom.d[k]) * $signed(axis[k]);
    end
    dsum = 52'(dp[0]) + 52'(dp[1]) + 52'(dp[2]);
    dabs = dsum[51] ? 52'(-dsum) : 52'(dsum);
    for (int m = 0; m < NUM_TERMS; m++) begin
      bx = (m < 3) ? geom.a_ax[m%3] : geom.b_ax[m%3];
      for (int k = 0; k < 3; k++) begin
        ap[m][k] = $signed(bx[k]) * $signed(axis[k]);
      end
      asum[m]   = 51'(ap[m][0]) + 51'(ap[m][1]) + 51'(ap[m][2]);
      aabs[m]   = asum[m][50] ? 51'(-asum[m]) : 51'(asum[m]);
      dm_nxt[m] = aabs[m][RM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    dist1_r <= dabs[DM_W-1:0];
    for (int m = 0; m < NUM_TERMS; m++) begin
      dm_r[m] <= dm_nxt[m];
      hm_r[m] <= (m < 3) ? geom.a_hm[m%3] : geom.b_hm[m%3];
    end
    // stage 2
    dist2_r <= dist1_r;
    for (int m = 0; m < NUM_TERMS; m++) begin
      term_r[m] <= TERM_W'(dm_r[m] * hm_r[m]);
    end
    // stage 3
    dist3_r <= dist2_r;
    for (int p = 0; p < 3; p++) begin
      pair_r[p] <= PAIR_W'(term_r[2*p]) + PAIR_W'(term_r[2*p+1]);
    end
    // stage 4
    dist4_r <= dist3_r;
    total_r <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + SUM_W'(pair_r[2]);
  end

  assign sep = SUM_W'({dist4_r, DIST_SH'(0)}) > total_r;

endmodule

// ===== rtl/obb_overlap_separating_axis_unit.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_separating_axis_unit
// Oriented-box overlap test over fifteen candidate axes, one box pair per
// clock, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                        | handshake
//  --------+------------------------------+------------------------------
//  request | start, busy, in_data         | taken when start && !busy
//  result  | out_strobe, out_data         | one-cycle strobe, no backpressure
//
//  A request is taken every cycle; busy stays low.
//  The result strobes after these registers in order: input register,
//  axis setup, four projection stages, output register.
//  rst_n (synchronous) clears the valid pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
module obb_overlap_separating_axis_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  obbsat_pkg::obbsat_in_t  in_data,
  output logic                    out_strobe,
  output obbsat_pkg::obbsat_out_t out_data
);
  import obbsat_pkg::*;

  localparam int PIPE = 6;

  obbsat_in_t   in_r;
  obbsat_geom_t geom;
  vl_t          axes [NUM_AXES];
  logic         eq_pair;
  logic [3:0]   eq_r;
  logic [PIPE-1:0] vld_r;
  logic [NUM_AXES-1:0] sep;
  logic         accept;
  logic         out_strobe_r;
  obbsat_out_t  res_nxt, res_r;
  logic         found;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[PIPE-2:0], accept};
      out_strobe_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    eq_r  <= {eq_r[2:0], eq_pair};
    res_r <= res_nxt;
  end

  obbsat_front u_front (
    .clk     (clk),
    .req     (in_r),
    .geom    (geom),
    .axes    (axes),
    .eq_pair (eq_pair)
  );

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    obbsat_axis_test u_axis (
      .clk  (clk),
      .geom (geom),
      .axis (axes[g]),
      .sep  (sep[g])
    );
  end

  // first separating face axis wins; else an equal axis pair skips the cross axes; else the first separating cross axis
  always_comb begin
    res_nxt.overlap    = 1'b1;
    res_nxt.split_axis = AXIS_NONE;
    found              = 1'b0;
    for (int a = 0; a < NUM_FACE; a++) begin
      if (!found && sep[a]) begin
        found              = 1'b1;
        res_nxt.overlap    = 1'b0;
        res_nxt.split_axis = 4'(a);
      end
    end
    if (!found && eq_r[3]) begin
      found = 1'b1;
    end
    for (int a = NUM_FACE; a < NUM_AXES; a++) begin
      if (!found && sep[a]) begin
        found              = 1'b1;
        res_nxt.overlap    = 1'b0;
        res_nxt.split_axis = 4'(a);
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = res_r;

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_strobe)
    else $error("request did not produce a result after 7 cycles");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 7))
    else $error("result without a matching request");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.overlap == (out_data.split_axis == AXIS_NONE)))
    else $error("overlap flag and axis index disagree");
`endif

endmodule
